FILE: rtl/core/tape_cycle_to_byte_decoder_core_defines.svh
// ----------------------------------------------------------------------------
// Tape cycle to byte decoder: assertion macros
// Shared helpers for the concurrent checks of the decoder core.
// ----------------------------------------------------------------------------
`ifndef TAPE_CYCLE_TO_BYTE_DECODER_CORE_DEFINES_SVH
`define TAPE_CYCLE_TO_BYTE_DECODER_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk and held off during reset.
`define TCBD_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and held off during reset.
`define TCBD_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/tcbd_pkg.sv
// ----------------------------------------------------------------------------
// tcbd_pkg
// Shared codes, widths and types of the tape cycle to byte decoder.
// ----------------------------------------------------------------------------
package tcbd_pkg;

  // Cycle kinds; the bit state uses the ambiguous code as "no kind yet".
  localparam logic [1:0] KIND_SHORT = 2'd0;
  localparam logic [1:0] KIND_LONG  = 2'd1;
  localparam logic [1:0] KIND_AMB   = 2'd2;
  localparam logic [1:0] KIND_NONE  = 2'd2;
  localparam logic [1:0] KIND_BAD   = 2'd3;

  // Result status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_CYCLE_ERR = 2'd1;
  localparam logic [1:0] ST_START_ERR = 2'd2;
  localparam logic [1:0] ST_STOP_ERR  = 2'd3;

  // Speed codes
  localparam logic [1:0] SPEED_300 = 2'd0;
  localparam logic [1:0] SPEED_600 = 2'd1;

  // Configuration register map
  localparam int CFG_AW = 1;
  localparam int CFG_DW = 2;
  localparam logic [CFG_AW-1:0] CFG_SPEED  = 1'b0;
  localparam logic [CFG_AW-1:0] CFG_STRICT = 1'b1;

  // Frame layout: start bit, 8 data bits, two stop bits
  localparam logic [3:0] FRAME_DATA_LAST = 4'd8;
  localparam logic [3:0] FRAME_LAST      = 4'd10;

  // Queue sizes (powers of two)
  localparam int EVQ_DEPTH  = 2;
  localparam int EVQ_PW     = $clog2(EVQ_DEPTH);
  localparam int EVQ_CW     = $clog2(EVQ_DEPTH + 1);
  localparam int RESQ_DEPTH = 2;
  localparam int RESQ_PW    = $clog2(RESQ_DEPTH);
  localparam int RESQ_CW    = $clog2(RESQ_DEPTH + 1);

  typedef struct packed {
    logic [1:0] speed;
    logic       strict;
  } cfg_t;

  // Bit event from the cycle classifier to the framer
  typedef struct packed {
    logic err;  // cycle/bit error, restart framing
    logic two;  // two bits finished by one cycle
    logic b0;   // first bit
    logic b1;   // second bit, valid when two is set
  } ev_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic [1:0] status;
  } res_t;

endpackage

FILE: rtl/core/tape_cycle_to_byte_decoder_core.sv
// Path: bit events are registered in the event queue and results in the result queue.
// Throughput: one cycle kind per clock while in_full is low; the classifier and the
// framer each take one event a cycle, and the two-entry event and result queues
// decouple the stalls.
// Reset: synchronous, active low; clears bit and framing state, both queues and the
// configuration (300 baud, strict mode off). No clearing pass is needed.
// ----------------------------------------------------------------------------
// tape_cycle_to_byte_decoder_core
// Decodes classified tape cycles into framed bytes or error codes.
// ----------------------------------------------------------------------------
`include "tape_cycle_to_byte_decoder_core_defines.svh"

module tape_cycle_to_byte_decoder_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [tcbd_pkg::CFG_AW-1:0]   cfg_addr,
  input  logic [tcbd_pkg::CFG_DW-1:0]   cfg_wdata,
  input  logic                          in_push,
  output logic                          in_full,
  input  logic [1:0]                    in_cycle_kind,
  output logic                          out_empty,
  input  logic                          out_pop,
  output logic [7:0]                    out_data_byte,
  output logic [1:0]                    out_status
);

  tcbd_pkg::cfg_t cfg_r;
  tcbd_pkg::ev_t  ev_in, ev_head;
  tcbd_pkg::res_t res, res_head;
  logic           in_acc;
  logic           ev_push, ev_pop, ev_empty, ev_full;
  logic           res_push, res_ready;
  logic           res_err;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        tcbd_pkg::CFG_SPEED:  cfg_r.speed  <= cfg_wdata;
        tcbd_pkg::CFG_STRICT: cfg_r.strict <= cfg_wdata[0];
      endcase
    end
  end

  assign in_full = ev_full;
  assign in_acc  = in_push && !ev_full;

  tcbd_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .acc        (in_acc),
    .cycle_kind (in_cycle_kind),
    .ev_push    (ev_push),
    .ev         (ev_in)
  );

  tcbd_evq u_evq (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (ev_push),
    .push_ev (ev_in),
    .pop     (ev_pop),
    .empty   (ev_empty),
    .full    (ev_full),
    .head    (ev_head)
  );

  tcbd_framer u_framer (
    .clk       (clk),
    .rst_n     (rst_n),
    .ev_valid  (!ev_empty),
    .ev        (ev_head),
    .res_ready (res_ready),
    .ev_pop    (ev_pop),
    .res_push  (res_push),
    .res       (res)
  );

  tcbd_resq u_resq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (res_push),
    .push_res (res),
    .pop      (out_pop),
    .ready    (res_ready),
    .empty    (out_empty),
    .head     (res_head)
  );

  assign out_data_byte = res_head.data_byte;
  assign out_status    = res_head.status;

  assign res_err = !out_empty && (out_status != tcbd_pkg::ST_OK);

  `TCBD_ASSERT_IMP(a_err_byte_zero, res_err, out_data_byte == 8'd0, "error result has a byte")
  `TCBD_ASSERT_NXT(a_evq_holds, ev_push, !ev_empty, "pushed bit event missing from queue")
  `TCBD_ASSERT_NXT(a_resq_holds, res_push, !out_empty, "pushed result missing from queue")
  `TCBD_ASSERT_IMP(a_res_room, res_push, res_ready, "result pushed into a full queue")

endmodule

FILE: rtl/core/tcbd_front.sv
// ----------------------------------------------------------------------------
// tcbd_front
// Groups classified tape cycles into bits and posts bit or error events.
// ----------------------------------------------------------------------------
module tcbd_front (
  input  logic              clk,
  input  logic              rst_n,
  input  tcbd_pkg::cfg_t    cfg,
  input  logic              acc,
  input  logic [1:0]        cycle_kind,
  output logic              ev_push,
  output tcbd_pkg::ev_t     ev
);

  logic [1:0] kind_r, kind_nxt;
  logic [3:0] cnt_r, cnt_nxt;
  logic       slip_r, slip_nxt;

  logic [1:0] c;
  logic [1:0] kind_eff;
  logic       known;
  logic       m1, m4;
  logic [3:0] cnt1;
  logic [3:0] expect_cnt;
  logic       bit_done, bit_val, err, reuse;

  assign c     = (cycle_kind == tcbd_pkg::KIND_BAD) ? tcbd_pkg::KIND_AMB : cycle_kind;
  assign known = (c != tcbd_pkg::KIND_AMB);
  assign m1    = (cfg.speed == tcbd_pkg::SPEED_300);
  assign m4    = (cfg.speed != tcbd_pkg::SPEED_300) && (cfg.speed != tcbd_pkg::SPEED_600);
  assign cnt1  = cnt_r + 4'd1;

  assign kind_eff = (kind_r == tcbd_pkg::KIND_NONE && known) ? c : kind_r;

  always_comb begin
    if (kind_eff == tcbd_pkg::KIND_SHORT) begin
      expect_cnt = m1 ? 4'd8 : (m4 ? 4'd2 : 4'd4);
    end else begin
      expect_cnt = m1 ? 4'd4 : (m4 ? 4'd1 : 4'd2);
    end
  end

  always_comb begin
    kind_nxt = kind_r;
    cnt_nxt  = cnt_r;
    slip_nxt = slip_r;
    bit_done = 1'b0;
    bit_val  = 1'b0;
    err      = 1'b0;
    reuse    = 1'b0;
    if (acc) begin
      if (cnt1 == 4'd1) begin
        if (c == tcbd_pkg::KIND_LONG && m4) begin
          // long first cycle at top speed is a whole zero bit
          bit_done = 1'b1;
          kind_nxt = tcbd_pkg::KIND_NONE;
          cnt_nxt  = 4'd0;
          slip_nxt = 1'b0;
        end else begin
          cnt_nxt = cnt1;
          if (known) begin
            kind_nxt = c;
          end
        end
      end else if (!cfg.strict && m1 && cnt1 == 4'd2 && known &&
                   kind_r != tcbd_pkg::KIND_NONE && c != kind_r) begin
        // leading slip: restart the bit on this cycle, once per bit
        if (slip_r) begin
          err      = 1'b1;
          kind_nxt = tcbd_pkg::KIND_NONE;
          cnt_nxt  = 4'd0;
          slip_nxt = 1'b0;
        end else begin
          slip_nxt = 1'b1;
          kind_nxt = c;
          cnt_nxt  = 4'd1;
        end
      end else if (kind_eff == tcbd_pkg::KIND_NONE) begin
        err      = 1'b1;
        kind_nxt = tcbd_pkg::KIND_NONE;
        cnt_nxt  = 4'd0;
        slip_nxt = 1'b0;
      end else if (cnt1 < expect_cnt) begin
        if (c != kind_eff) begin
          err      = 1'b1;
          kind_nxt = tcbd_pkg::KIND_NONE;
          cnt_nxt  = 4'd0;
          slip_nxt = 1'b0;
        end else begin
          kind_nxt = kind_eff;
          cnt_nxt  = cnt1;
        end
      end else begin
        bit_done = 1'b1;
        bit_val  = (kind_eff == tcbd_pkg::KIND_SHORT);
        reuse    = known && (c != kind_eff);
        kind_nxt = tcbd_pkg::KIND_NONE;
        cnt_nxt  = 4'd0;
        slip_nxt = 1'b0;
        if (reuse && !(c == tcbd_pkg::KIND_LONG && m4)) begin
          // trailing conflict: the cycle opens the next bit
          kind_nxt = c;
          cnt_nxt  = 4'd1;
        end
      end
    end
  end

  always_comb begin
    ev.err  = err;
    ev.b0   = bit_val;
    // a reused long cycle at top speed finishes a zero bit on its own
    ev.two  = reuse && (c == tcbd_pkg::KIND_LONG) && m4;
    ev.b1   = 1'b0;
    ev_push = err || bit_done;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kind_r <= tcbd_pkg::KIND_NONE;
      cnt_r  <= 4'd0;
      slip_r <= 1'b0;
    end else begin
      kind_r <= kind_nxt;
      cnt_r  <= cnt_nxt;
      slip_r <= slip_nxt;
    end
  end

endmodule

FILE: rtl/core/tcbd_evq.sv
// ----------------------------------------------------------------------------
// tcbd_evq
// Short queue of bit events between the cycle classifier and the framer.
// ----------------------------------------------------------------------------
module tcbd_evq (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  tcbd_pkg::ev_t  push_ev,
  input  logic           pop,
  output logic           empty,
  output logic           full,
  output tcbd_pkg::ev_t  head
);

  tcbd_pkg::ev_t                 mem_r [tcbd_pkg::EVQ_DEPTH];
  logic [tcbd_pkg::EVQ_PW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [tcbd_pkg::EVQ_CW-1:0]   cnt_r, cnt_nxt;

  assign empty = (cnt_r == '0);
  assign full  = (cnt_r == tcbd_pkg::EVQ_CW'(tcbd_pkg::EVQ_DEPTH));
  assign head  = mem_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_ev;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
  end

endmodule

FILE: rtl/core/tcbd_framer.sv
// ----------------------------------------------------------------------------
// tcbd_framer
// Frames bits as start, 8 data bits LSB first and two stop bits.
// ----------------------------------------------------------------------------
module tcbd_framer (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            ev_valid,
  input  tcbd_pkg::ev_t   ev,
  input  logic            res_ready,
  output logic            ev_pop,
  output logic            res_push,
  output tcbd_pkg::res_t  res
);

  typedef struct packed {
    logic [3:0] idx;
    logic [7:0] sh;
    logic       emit;
    logic [1:0] status;
    logic [7:0] data_byte;
  } fr_t;

  function automatic fr_t frame_step(input logic [3:0] idx, input logic [7:0] sh,
                                     input logic b);
    fr_t f;
    f.idx       = idx;
    f.sh        = sh;
    f.emit      = 1'b0;
    f.status    = tcbd_pkg::ST_OK;
    f.data_byte = 8'd0;
    if (idx == 4'd0) begin
      if (b) begin
        f.emit   = 1'b1;
        f.status = tcbd_pkg::ST_START_ERR;
        f.sh     = 8'd0;
      end else begin
        f.idx = 4'd1;
      end
    end else if (idx <= tcbd_pkg::FRAME_DATA_LAST) begin
      f.sh  = {b, sh[7:1]};
      f.idx = idx + 4'd1;
    end else if (!b) begin
      f.emit   = 1'b1;
      f.status = tcbd_pkg::ST_STOP_ERR;
      f.idx    = 4'd0;
      f.sh     = 8'd0;
    end else if (idx >= tcbd_pkg::FRAME_LAST) begin
      f.emit      = 1'b1;
      f.data_byte = sh;
      f.idx       = 4'd0;
      f.sh        = 8'd0;
    end else begin
      f.idx = idx + 4'd1;
    end
    return f;
  endfunction

  logic [3:0] idx_r, idx_nxt;
  logic [7:0] sh_r, sh_nxt;
  fr_t        s1, s2;
  logic       go;

  assign go     = ev_valid && res_ready;
  assign ev_pop = go;
  assign s1     = frame_step(idx_r, sh_r, ev.b0);
  assign s2     = frame_step(s1.idx, s1.sh, ev.b1);

  always_comb begin
    idx_nxt       = idx_r;
    sh_nxt        = sh_r;
    res_push      = 1'b0;
    res.data_byte = 8'd0;
    res.status    = tcbd_pkg::ST_CYCLE_ERR;
    if (go) begin
      if (ev.err) begin
        res_push = 1'b1;
        idx_nxt  = 4'd0;
        sh_nxt   = 8'd0;
      end else begin
        idx_nxt = ev.two ? s2.idx : s1.idx;
        sh_nxt  = ev.two ? s2.sh : s1.sh;
        // only the first result of a double bit is delivered
        if (s1.emit) begin
          res_push      = 1'b1;
          res.data_byte = s1.data_byte;
          res.status    = s1.status;
        end else if (ev.two && s2.emit) begin
          res_push      = 1'b1;
          res.data_byte = s2.data_byte;
          res.status    = s2.status;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= 4'd0;
      sh_r  <= 8'd0;
    end else begin
      idx_r <= idx_nxt;
      sh_r  <= sh_nxt;
    end
  end

endmodule

FILE: rtl/core/tcbd_resq.sv
// ----------------------------------------------------------------------------
// tcbd_resq
// Result queue feeding the output channel; takes a push while popping.
// ----------------------------------------------------------------------------
module tcbd_resq (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  tcbd_pkg::res_t  push_res,
  input  logic            pop,
  output logic            ready,
  output logic            empty,
  output tcbd_pkg::res_t  head
);

  tcbd_pkg::res_t                mem_r [tcbd_pkg::RESQ_DEPTH];
  logic [tcbd_pkg::RESQ_PW-1:0]  wr_ptr_r, rd_ptr_r;
  logic [tcbd_pkg::RESQ_CW-1:0]  cnt_r, cnt_nxt;
  logic                          pop_ok;

  assign empty  = (cnt_r == '0);
  assign pop_ok = pop && !empty;
  assign ready  = (cnt_r != tcbd_pkg::RESQ_CW'(tcbd_pkg::RESQ_DEPTH)) || pop_ok;
  assign head   = mem_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop_ok) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop_ok && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop_ok) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
  end

endmodule

FILE: tb/tape_cycle_to_byte_decoder_core_test.sv
// ----------------------------------------------------------------------------
// tape_cycle_to_byte_decoder_core_test
// Streams classified tape cycles into the decoder core: framed bytes at all
// speeds with tolerated ambiguous edges, slips and trailing conflicts, plus
// broken frames and noise. A cycle-level decoder model predicts each byte or
// error code, and every popped result is checked against it in order.
// ----------------------------------------------------------------------------
module tape_cycle_to_byte_decoder_core_test;
  import tcbd_pkg::*;

  localparam logic [1:0] SPEED_1200     = 2'd2;
  localparam logic [1:0] SPEED_1200_ALT = 2'd3;
  localparam int ONE_CYCLES   = 8;
  localparam int ZERO_CYCLES  = 4;
  localparam int DRAIN_CYCLES = 8;
  localparam int HOLD_CYCLES  = 200;
  localparam int LIMIT_CYCLES = 400000;

  // Frame damage applied by the stimulus generator
  localparam int FLAW_NONE  = 0;
  localparam int FLAW_START = 1;
  localparam int FLAW_STOP  = 2;
  localparam int FLAW_CUT   = 3;

  typedef enum logic [1:0] {BIT_ZERO, BIT_ONE, BIT_OPEN, BIT_FAULT} bit_step_t;

  logic              clk;
  logic              rst_n         = 1'b0;
  logic              cfg_we        = 1'b0;
  logic [CFG_AW-1:0] cfg_addr      = CFG_SPEED;
  logic [CFG_DW-1:0] cfg_wdata     = '0;
  logic              in_push       = 1'b0;
  logic              in_full;
  logic [1:0]        in_cycle_kind = KIND_SHORT;
  logic              out_empty;
  logic              out_pop       = 1'b0;
  logic [7:0]        out_data_byte;
  logic [1:0]        out_status;

  tape_cycle_to_byte_decoder_core DUT (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_addr      (cfg_addr),
    .cfg_wdata     (cfg_wdata),
    .in_push       (in_push),
    .in_full       (in_full),
    .in_cycle_kind (in_cycle_kind),
    .out_empty     (out_empty),
    .out_pop       (out_pop),
    .out_data_byte (out_data_byte),
    .out_status    (out_status)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Decoder model state and its copy of the registers
  logic [1:0] cur_speed  = SPEED_300;
  logic       cur_strict = 1'b0;
  logic [1:0] bit_kind   = KIND_NONE;
  logic [3:0] bit_count  = 4'd0;
  logic       slip_taken = 1'b0;
  logic [3:0] frame_pos  = 4'd0;
  logic [7:0] shift_reg  = 8'd0;

  res_t       decoded_q[$];
  logic [1:0] cycle_fifo[$];

  int tx_idle_pct   = 20;
  int rx_idle_pct   = 20;
  logic pressure_go   = 1'b0;
  logic pressure_done = 1'b0;
  logic gen_carry     = 1'b0;
  int phase_items;
  int items_in      = 0;
  int fail_cnt      = 0;
  int status_seen[4] = '{0, 0, 0, 0};
  int cycle_cnt     = 0;

  function automatic int unsigned speed_div(input logic [1:0] s);
    case (s)
      SPEED_300: return 1;
      SPEED_600: return 2;
      default:   return 4;
    endcase
  endfunction

  function automatic void clear_bit();
    bit_kind   = KIND_NONE;
    bit_count  = 4'd0;
    slip_taken = 1'b0;
  endfunction

  function automatic void clear_frame();
    frame_pos = 4'd0;
    shift_reg = 8'd0;
  endfunction

  // Advance the bit grouping by one cycle.
  function automatic bit_step_t bit_from_cycle(input logic [1:0] c, output logic reuse);
    int unsigned m;
    int unsigned need;
    logic known;
    m = speed_div(cur_speed);
    known = (c == KIND_SHORT) || (c == KIND_LONG);
    reuse = 1'b0;
    bit_count = bit_count + 4'd1;
    if (bit_count == 4'd1) begin
      if (c == KIND_LONG && m == 4) begin
        clear_bit();
        return BIT_ZERO;
      end
      if (known) bit_kind = c;
      return BIT_OPEN;
    end
    // leading slip: restart the bit on the conflicting cycle, only once
    if (!cur_strict && m == 1 && bit_count == 4'd2 && known &&
        bit_kind != KIND_NONE && c != bit_kind) begin
      if (slip_taken) begin
        clear_bit();
        return BIT_FAULT;
      end
      slip_taken = 1'b1;
      bit_kind   = c;
      bit_count  = 4'd1;
      return BIT_OPEN;
    end
    if (bit_kind == KIND_NONE && known) bit_kind = c;
    if (bit_kind == KIND_NONE) begin
      clear_bit();
      return BIT_FAULT;
    end
    need = ((bit_kind == KIND_SHORT) ? ONE_CYCLES : ZERO_CYCLES) / m;
    if (bit_count < need) begin
      if (c != bit_kind) begin
        clear_bit();
        return BIT_FAULT;
      end
      return BIT_OPEN;
    end
    reuse = known && (c != bit_kind);
    if (bit_kind == KIND_SHORT) begin
      clear_bit();
      return BIT_ONE;
    end
    clear_bit();
    return BIT_ZERO;
  endfunction

  // Feed one bit to the framer; returns 1 when a result is produced.
  function automatic logic frame_push(input logic b, output res_t r);
    r = '0;
    if (frame_pos == 4'd0) begin
      if (b) begin
        clear_frame();
        r.status = ST_START_ERR;
        return 1'b1;
      end
      frame_pos = 4'd1;
      return 1'b0;
    end
    if (frame_pos <= FRAME_DATA_LAST) begin
      shift_reg = {b, shift_reg[7:1]};
      frame_pos = frame_pos + 4'd1;
      return 1'b0;
    end
    if (!b) begin
      clear_frame();
      r.status = ST_STOP_ERR;
      return 1'b1;
    end
    if (frame_pos >= FRAME_LAST) begin
      r.data_byte = shift_reg;
      r.status    = ST_OK;
      clear_frame();
      return 1'b1;
    end
    frame_pos = frame_pos + 4'd1;
    return 1'b0;
  endfunction

  function automatic void decode_cycle(input logic [1:0] raw);
    logic [1:0] c;
    logic reuse;
    logic reuse2;
    logic got;
    res_t r;
    res_t spare;
    bit_step_t o;
    c = (raw == KIND_BAD) ? KIND_AMB : raw;
    got = 1'b0;
    r = '0;
    o = bit_from_cycle(c, reuse);
    if (o == BIT_FAULT) begin
      clear_frame();
      r.status = ST_CYCLE_ERR;
      decoded_q.push_back(r);
      return;
    end
    if (o == BIT_ZERO || o == BIT_ONE) got = frame_push(o == BIT_ONE, r);
    // a trailing conflict also opens the next bit; drop a second result
    if (reuse) begin
      o = bit_from_cycle(c, reuse2);
      if (o == BIT_ZERO || o == BIT_ONE) begin
        if (got) void'(frame_push(o == BIT_ONE, spare));
        else got = frame_push(o == BIT_ONE, r);
      end
    end
    if (got) decoded_q.push_back(r);
  endfunction

  // ---------------- stimulus generation ----------------

  function automatic void put_cycle(input logic [1:0] k);
    cycle_fifo.push_back(k);
    phase_items++;
  endfunction

  function automatic void add_bit(input logic b, input logic nxt_valid, input logic nxt);
    int unsigned m;
    int unsigned n;
    int unsigned cnt;
    int unsigned v;
    int unsigned i;
    logic [1:0] k;
    logic [1:0] kk;
    logic trail;
    m = speed_div(cur_speed);
    k = b ? KIND_SHORT : KIND_LONG;
    n = (b ? ONE_CYCLES : ZERO_CYCLES) / m;
    cnt = gen_carry ? n - 1 : n;
    trail = nxt_valid && (nxt != b) && n >= 2 && cnt >= 1 && $urandom_range(3) == 0;
    v = $urandom_range(9);
    if (trail || gen_carry) v = 9;
    // slip variants only make sense at the slowest speed
    if (v == 2 && cur_speed != SPEED_300) v = 9;
    if (v == 1 && n < 2) v = 9;
    if (v == 2) put_cycle(b ? KIND_LONG : KIND_SHORT);
    if (v == 0 && n == 1) put_cycle(KIND_AMB);
    for (i = 0; i < cnt; i++) begin
      kk = k;
      if (i == 0 && v == 0 && n >= 2) kk = KIND_AMB;
      if (i == cnt - 1 && v == 1) kk = KIND_AMB;
      if (i == cnt - 1 && trail) kk = nxt ? KIND_SHORT : KIND_LONG;
      put_cycle(kk);
    end
    gen_carry = trail;
  endfunction

  function automatic void add_frame(input logic [7:0] data, input int flaw);
    logic [10:0] bits;
    int nb;
    int i;
    bits = {2'b11, data, 1'b0};
    nb = 11;
    case (flaw)
      FLAW_START: bits[0] = 1'b1;
      FLAW_STOP:  bits[$urandom_range(10, 9)] = 1'b0;
      FLAW_CUT:   nb = $urandom_range(9, 3);
      default: ;
    endcase
    for (i = 0; i < nb; i++)
      add_bit(bits[i], i < nb - 1, (i < 10) ? bits[i + 1] : 1'b0);
  endfunction

  function automatic void add_noise(input int n);
    int i;
    for (i = 0; i < n; i++) put_cycle(2'($urandom_range(3)));
    gen_carry = 1'b0;
  endfunction

  // ---------------- sender ----------------

  int tx_gap = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_push <= 1'b0;
      tx_gap  = 0;
    end else begin
      if (in_push && !in_full) begin
        decode_cycle(in_cycle_kind);
        void'(cycle_fifo.pop_front());
        items_in++;
      end
      // hold the offered cycle until it transfers
      if (!(in_push && in_full)) begin
        if (tx_gap == 0 && $urandom_range(99) < tx_idle_pct)
          tx_gap = $urandom_range(3, 1);
        if (tx_gap > 0) begin
          tx_gap--;
          in_push <= 1'b0;
        end else if (cycle_fifo.size() > 0) begin
          in_push       <= 1'b1;
          in_cycle_kind <= cycle_fifo[0];
        end else begin
          in_push <= 1'b0;
        end
      end
    end
  end

  // ---------------- receiver and checker ----------------

  int rx_gap  = 0;
  int rx_hold = 0;
  res_t want;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else begin
      if (out_pop && !out_empty) begin
        status_seen[out_status]++;
        if (decoded_q.size() == 0) begin
          fail_cnt++;
          $display("%0t: result with none expected: status %0d, byte %h",
                   $time, out_status, out_data_byte);
        end else begin
          want = decoded_q.pop_front();
          if (out_status !== want.status) begin
            fail_cnt++;
            $display("%0t: status mismatch: expected %0d, actual %0d",
                     $time, want.status, out_status);
          end
          if (out_data_byte !== want.data_byte) begin
            fail_cnt++;
            $display("%0t: data_byte mismatch: expected %h, actual %h",
                     $time, want.data_byte, out_data_byte);
          end
        end
      end
      if (pressure_go && !pressure_done) begin
        rx_hold       = HOLD_CYCLES;
        pressure_done = 1'b1;
      end
      if (rx_hold > 0) begin
        rx_hold--;
        out_pop <= 1'b0;
      end else begin
        if (rx_gap == 0 && $urandom_range(99) < rx_idle_pct)
          rx_gap = $urandom_range(3, 1);
        if (rx_gap > 0) begin
          rx_gap--;
          out_pop <= 1'b0;
        end else begin
          out_pop <= 1'b1;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > LIMIT_CYCLES) begin
      $display("%0t: timeout with %0d cycles queued and %0d results outstanding",
               $time, cycle_fifo.size(), decoded_q.size());
      $display("tape_cycle_to_byte_decoder_core verification failed");
      $finish;
    end
  end

  // ---------------- sequencing ----------------

  // Wait until every queued cycle has transferred and every result has come back.
  task automatic settle();
    while (cycle_fifo.size() != 0 || in_push || decoded_q.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic apply_config(input logic [1:0] speed, input logic strict);
    cfg_we    <= 1'b1;
    cfg_addr  <= CFG_SPEED;
    cfg_wdata <= speed;
    @(posedge clk);
    cfg_addr  <= CFG_STRICT;
    cfg_wdata <= {1'b0, strict};
    @(posedge clk);
    cfg_we     <= 1'b0;
    cur_speed  = speed;
    cur_strict = strict;
    gen_carry  = 1'b0;
  endtask

  task automatic run_phase(input logic [1:0] speed, input logic strict, input int tx,
                           input int rx, input int goal, input logic squeeze);
    int sel;
    logic [7:0] data;
    apply_config(speed, strict);
    tx_idle_pct = tx;
    rx_idle_pct = rx;
    if (squeeze) pressure_go = 1'b1;
    phase_items = 0;
    while (phase_items < goal) begin
      sel = $urandom_range(99);
      case ($urandom_range(7))
        0:       data = 8'h00;
        1:       data = 8'hFF;
        default: data = 8'($urandom);
      endcase
      if (sel < 75) add_frame(data, FLAW_NONE);
      else if (sel < 88) add_frame(data, $urandom_range(FLAW_CUT, FLAW_START));
      else add_noise($urandom_range(6, 1));
    end
    settle();
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Slowest speed, slip allowed
    apply_config(SPEED_300, 1'b0);
    put_cycle(KIND_AMB); put_cycle(KIND_BAD);                         // two ambiguous
    put_cycle(KIND_SHORT); put_cycle(KIND_LONG); put_cycle(KIND_LONG);
    put_cycle(KIND_LONG); put_cycle(KIND_LONG);                       // slip, then zero
    put_cycle(KIND_SHORT); put_cycle(KIND_LONG); put_cycle(KIND_SHORT); // second slip
    put_cycle(KIND_LONG); put_cycle(KIND_LONG); put_cycle(KIND_LONG);
    put_cycle(KIND_SHORT);                                            // trailing conflict
    repeat (7) put_cycle(KIND_SHORT);
    settle();

    // Fastest speed: long first bit, long after ambiguous, double bit
    apply_config(SPEED_1200, 1'b0);
    put_cycle(KIND_LONG);
    put_cycle(KIND_AMB); put_cycle(KIND_LONG);
    put_cycle(KIND_SHORT); put_cycle(KIND_LONG);
    settle();

    run_phase(SPEED_300,      1'b0, 20, 20, 300, 1'b0);
    run_phase(SPEED_600,      1'b0, 30, 10, 250, 1'b0);
    run_phase(SPEED_1200,     1'b1,  0,  0, 250, 1'b1);
    run_phase(SPEED_300,      1'b1, 15, 40, 250, 1'b0);
    run_phase(SPEED_1200_ALT, 1'b0, 25, 25, 250, 1'b0);
    run_phase(SPEED_600,      1'b1, 10, 30, 250, 1'b0);
    run_phase(SPEED_1200,     1'b0,  0,  0, 250, 1'b0);

    $display("Fed %0d tape cycles over nine speed/strict settings, with idle bursts and %s",
             items_in, "one long output stall.");
    $display("Checked %0d bytes, %0d cycle errors, %0d start errors, %0d stop errors.",
             status_seen[ST_OK], status_seen[ST_CYCLE_ERR], status_seen[ST_START_ERR],
             status_seen[ST_STOP_ERR]);
    if (decoded_q.size() != 0)
      $display("%0t: %0d expected results never arrived", $time, decoded_q.size());
    if (fail_cnt == 0 && decoded_q.size() == 0) begin
      $display("tape_cycle_to_byte_decoder_core verification clean");
    end else begin
      $display("tape_cycle_to_byte_decoder_core verification failed");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+rtl/core
rtl/core/tcbd_pkg.sv
rtl/core/tcbd_front.sv
rtl/core/tcbd_evq.sv
rtl/core/tcbd_framer.sv
rtl/core/tcbd_resq.sv
rtl/core/tape_cycle_to_byte_decoder_core.sv
tb/tape_cycle_to_byte_decoder_core_test.sv
